// ===== src/cfbc_pkg.sv =====
`default_nettype none
package cfbc_pkg;

   localparam int FRAME_LEN = 8;
   localparam int CRC_SPAN  = 6;
   localparam int INDEX_W   = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Command codes. The DATA codes carry the payload, the QUERY codes send zeros.
   localparam logic [7:0] CMD_DATA_A  = 8'h01;
   localparam logic [7:0] CMD_DATA_B  = 8'h02;
   localparam logic [7:0] CMD_QUERY_A = 8'h03;
   localparam logic [7:0] CMD_DATA_C  = 8'h04;
   localparam logic [7:0] CMD_QUERY_B = 8'h05;

   // One classified request waiting to be serialized.
   typedef struct packed {
      logic [7:0]  device_id;
      logic [7:0]  command;
      logic [31:0] payload;
   } entry_type;

   // Write side of the queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Read side of the queue as seen by the serializer.
   typedef struct packed {
      logic      empty;
      entry_type entry;
   } head_type;

   // One byte of CRC-16/MODBUS, reflected, one bit per step.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] acc;
      acc = crc_in ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

// ===== src/cfbc_front.sv =====
`default_nettype none
module cfbc_front
   import cfbc_pkg::*;
(
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [7:0]  req_command,
   input  wire logic [31:0] req_payload,
   input  wire logic        queue_full,
   output logic             req_stall,
   output push_type         push
);

   logic known;
   logic with_payload;

   always_comb begin
      known        = 1'b1;
      with_payload = 1'b0;
      case (req_command) inside
         CMD_DATA_A, CMD_DATA_B, CMD_DATA_C: with_payload = 1'b1;
         CMD_QUERY_A, CMD_QUERY_B:           with_payload = 1'b0;
         default:                            known        = 1'b0;
      endcase
   end

   // Unknown commands are taken and dropped; only known ones reach the queue.
   assign req_stall            = queue_full;
   assign push.valid           = req_valid & ~queue_full & known;
   assign push.entry.device_id = req_device_id;
   assign push.entry.command   = req_command;
   assign push.entry.payload   = with_payload ? req_payload : 32'h0000_0000;

endmodule
`default_nettype wire

// ===== src/cfbc_queue.sv =====
`default_nettype none
module cfbc_queue
   import cfbc_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  wire logic clock,
   input  wire logic reset,
   input  wire push_type push,
   input  wire logic pop,
   output logic      full,
   output head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.entry = store_ff[rd_ptr_ff];
   assign do_push    = push.valid & ~full;
   assign do_pop     = pop & ~head.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule
`default_nettype wire

// ===== src/cfbc_back.sv =====
`default_nettype none
module cfbc_back
   import cfbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire head_type   head,
   output logic            pop,
   input  wire logic       rsp_stall,
   output logic            rsp_valid,
   output logic [7:0]      rsp_frame_byte,
   output logic            rsp_last
);

   logic [INDEX_W-1:0] index_ff, index_in;
   logic [15:0]        crc_ff, crc_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               advance;
   logic               step;
   logic [15:0]        crc_cur;
   logic [7:0]         sel_byte;

   assign advance = ~valid_ff | ~rsp_stall;
   assign step    = advance & ~head.empty;
   assign crc_cur = (index_ff == '0) ? CRC_INIT : crc_ff;

   always_comb begin
      case (index_ff)
         3'd0:    sel_byte = head.entry.device_id;
         3'd1:    sel_byte = head.entry.command;
         3'd2:    sel_byte = head.entry.payload[7:0];
         3'd3:    sel_byte = head.entry.payload[15:8];
         3'd4:    sel_byte = head.entry.payload[23:16];
         3'd5:    sel_byte = head.entry.payload[31:24];
         3'd6:    sel_byte = crc_ff[7:0];
         default: sel_byte = crc_ff[15:8];
      endcase
   end

   always_comb begin
      index_in = index_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = step;
      end
      if (step) begin
         byte_in  = sel_byte;
         last_in  = (index_ff == INDEX_W'(FRAME_LEN - 1));
         index_in = index_ff + 1'b1;
         pop      = last_in;
         if (index_ff < INDEX_W'(CRC_SPAN)) begin
            crc_in = crc_byte(crc_cur, sel_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

// ===== src/command_frame_builder_crc16_core.sv =====
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   device_id[8], command[8], payload[32]
// rsp      out        rsp_valid/rsp_stall   frame_byte[8], last[1]
//
// Each known request becomes an 8-byte frame, one item per cycle on rsp while
// rsp_stall is low; the serializer in the back end sets that rate.
// Requests with unknown commands are taken and produce nothing.
// When the queue is empty, the first byte of a frame passes through the queue storage, then the output register.
// Reset is synchronous and clears the queue and the serializer; no clearing pass.
// req_stall rises only when the request queue is full; rsp_stall holds the
// output register while the front end keeps filling the queue.
module command_frame_builder_crc16_core
   import cfbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [7:0]  req_command,
   input  wire logic [31:0] req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last
);

   // Front end and back end meet only through the queue.
   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   cfbc_front u_front (
      .req_valid     (req_valid),
      .req_device_id (req_device_id),
      .req_command   (req_command),
      .req_payload   (req_payload),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push)
   );

   cfbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // The back end walks the queue head byte by byte, folds bytes 0 to 5 into
   // the CRC as they leave, and releases the entry with the final byte.
   cfbc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// ===== bench/frame_checker.sv =====
`timescale 1ns / 1ps
module frame_checker
   import cfbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [7:0]  req_command,
   input  wire logic [31:0] req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_frame_byte,
   input  wire logic        rsp_last,
   output int               failures,
   output int               bytes_due
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } frame_byte_type;

   frame_byte_type frame_bytes_due[$];
   int             fail_tally = 0;

   // Builds the frame that one request should produce and queues its bytes.
   task automatic queue_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input logic [31:0] raw);
      logic [7:0]     bytes [FRAME_LEN];
      logic [31:0]    body;
      logic [15:0]    crc;
      logic           known;
      frame_byte_type item;
      int             k;
      int             b;
      known = 1'b1;
      body  = '0;
      case (cmd)
         CMD_DATA_A, CMD_DATA_B, CMD_DATA_C: begin
            body = raw;
         end
         CMD_QUERY_A, CMD_QUERY_B: begin
            body = '0;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (known) begin
         bytes[0] = id;
         bytes[1] = cmd;
         bytes[2] = body[7:0];
         bytes[3] = body[15:8];
         bytes[4] = body[23:16];
         bytes[5] = body[31:24];
         crc = CRC_INIT;
         for (k = 0; k < CRC_SPAN; k++) begin
            crc = crc ^ {8'h00, bytes[k]};
            for (b = 0; b < 8; b++) begin
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
         end
         bytes[6] = crc[7:0];
         bytes[7] = crc[15:8];
         for (k = 0; k < FRAME_LEN; k++) begin
            item.value   = bytes[k];
            item.is_last = (k == FRAME_LEN - 1);
            frame_bytes_due.push_back(item);
         end
      end
   endtask

   // Results are checked before the request of the same edge is queued, since
   // a frame never starts on the edge that accepts its request.
   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         frame_bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               fail_tally++;
               if (fail_tally <= MAX_REPORTS) begin
                  $display("unexpected frame byte %02h last %0b with nothing pending",
                           rsp_frame_byte, rsp_last);
               end
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== want.value || rsp_last !== want.is_last) begin
                  fail_tally++;
                  if (fail_tally <= MAX_REPORTS) begin
                     $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                              want.value, want.is_last, rsp_frame_byte, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            queue_frame(req_device_id, req_command, req_payload);
         end
      end
      failures  <= fail_tally;
      bytes_due <= frame_bytes_due.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import cfbc_pkg::*;

   // Number of random requests after the directed ones, known and unknown alike.
   localparam int RANDOM_ITEMS = 194;
   // Cycles without any accepted item before the run is declared hung.
   localparam int IDLE_LIMIT    = 2000;
   // Quiet cycles after the last expected byte, to catch stray output.
   localparam int DRAIN_CYCLES  = 24;

   // Command codes outside the known set, used to check that they are dropped.
   localparam logic [7:0] CMD_UNUSED_ZERO = 8'h00;
   localparam logic [7:0] CMD_UNUSED_NEXT = CMD_QUERY_B + 8'h01;
   localparam logic [7:0] CMD_UNUSED_MID  = 8'h80;
   localparam logic [7:0] CMD_UNUSED_TOP  = 8'hFF;

   typedef enum logic [1:0] {
      STALL_OFF,
      STALL_LIGHT,
      STALL_HALF,
      STALL_HEAVY
   } stall_mode_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [7:0]  req_device_id  = '0;
   logic [7:0]  req_command    = '0;
   logic [31:0] req_payload    = '0;
   logic        rsp_stall      = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [7:0]  rsp_frame_byte;
   wire         rsp_last;

   int             mismatch_total;
   int             bytes_outstanding;
   int             idle_cycles      = 0;
   int             burst_left       = 0;
   int             stall_phase_left = 0;
   stall_mode_type stall_mode       = STALL_OFF;

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   command_frame_builder_crc16_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_device_id  (req_device_id),
      .req_command    (req_command),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last       (rsp_last)
   );

   // The checker watches both channels on its own and predicts every frame.
   frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_device_id  (req_device_id),
      .req_command    (req_command),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last       (rsp_last),
      .failures       (mismatch_total),
      .bytes_due      (bytes_outstanding)
   );

   // The receiver stalls in phases of random length. Each phase picks how hard
   // it pushes back, from never to nearly always, so stalls land on every byte
   // of a frame and the request queue in the block gets filled up as well.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_phase_left = $urandom_range(1, 64);
         if (stall_mode == STALL_HEAVY) begin
            // A heavy phase is always followed by a free-running one.
            stall_mode = STALL_OFF;
         end else begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
      end
      stall_phase_left--;
      case (stall_mode)
         STALL_OFF: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HALF: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // Watchdog: any accepted item on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request and returns on the edge that accepts it. The sender
   // works in bursts: when a burst runs out, valid drops for a random gap.
   // Valid that stays high across items is never lowered in between.
   task automatic send_request(input logic [7:0] id, input logic [7:0] cmd,
                               input logic [31:0] raw);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Occasional long bursts give stretches with no sender idling.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_device_id <= id;
      req_command   <= cmd;
      req_payload   <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int         items_sent;
      logic [7:0] cmd;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme ids and payloads on every payload command.
      send_request(8'h00, CMD_DATA_A,  32'h0000_0000);
      send_request(8'hFF, CMD_DATA_A,  32'hFFFF_FFFF);
      send_request(8'h5A, CMD_DATA_B,  32'h8000_0001);
      send_request(8'hA5, CMD_DATA_C,  32'h1234_5678);
      send_request(8'h01, CMD_DATA_B,  32'hFFFF_FFFF);
      send_request(8'hFE, CMD_DATA_C,  32'h0000_0000);
      // Query commands must send zeros no matter what the payload holds.
      send_request(8'h00, CMD_QUERY_A, 32'h0000_0000);
      send_request(8'hFF, CMD_QUERY_A, 32'hFFFF_FFFF);
      send_request(8'h7F, CMD_QUERY_B, 32'hDEAD_BEEF);
      send_request(8'h80, CMD_QUERY_B, 32'h0000_0000);
      // Unknown commands produce nothing, alone, back to back and between frames.
      send_request(8'h11, CMD_UNUSED_ZERO, 32'hFFFF_FFFF);
      send_request(8'h22, CMD_DATA_A,      32'hCAFE_F00D);
      send_request(8'h33, CMD_UNUSED_NEXT, 32'h0000_0000);
      send_request(8'h44, CMD_UNUSED_MID,  32'h5555_AAAA);
      send_request(8'h55, CMD_UNUSED_TOP,  32'hAAAA_5555);
      send_request(8'hFF, CMD_DATA_C,      32'hFFFF_FFFF);

      // Random part: mostly known commands, with some unknown codes mixed in.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 4))
               0:       cmd = CMD_DATA_A;
               1:       cmd = CMD_DATA_B;
               2:       cmd = CMD_DATA_C;
               3:       cmd = CMD_QUERY_A;
               default: cmd = CMD_QUERY_B;
            endcase
         end else begin
            cmd = 8'($urandom_range(0, 255));
         end
         items_sent++;
         send_request(8'($urandom_range(0, 255)), cmd, $urandom);
      end
      req_valid <= 1'b0;

      // The wait below lets the checker's count take in the last request.
      @(posedge clock);
      while (bytes_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0 && bytes_outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
